@@ hdl/kpbe_pkg.sv @@
// Package for the k-mer position bit extract block: widths, register indexes,
// command codes and reset values. No dependencies.
package kpbe_pkg;

    localparam int MAX_KMER_LENGTH      = 32;
    localparam int MAX_HASHED_POSITIONS = 16;

    localparam int KLEN_W   = 6;
    localparam int POS_W    = 32;
    localparam int KMER_W   = 64;
    localparam int OUT_W    = 32;
    localparam int CMD_W    = 2;
    localparam int DEST_W   = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASHED_POSITIONS = 4'd1;

    // commands
    localparam logic [CMD_W-1:0] CMD_HASH_BP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DROP_LR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP_BP = 2'd2;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd32;
    localparam logic [POS_W-1:0]  HPOS_RESET = 32'd0;

    typedef logic [DEST_W-1:0] dest_t;

endpackage

@@ hdl/kmer_position_bit_extract.sv @@
// An accepted item is registered with its command, then its result is registered with done high.
// Throughput: one transaction per cycle while busy is low; the receiver cannot stall.
// Masks and bit destinations settle in two register stages after a configuration write;
// busy is high in the cycle after each write, and until the first edge after reset.
// Reset: configuration returns to k = 32 and no hashed positions; pipeline empties.
// Depends on kpbe_pkg.
module kmer_position_bit_extract (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [kpbe_pkg::CMD_W-1:0]        command,
    input  logic [kpbe_pkg::KMER_W-1:0]       encoded_kmer,
    output logic                              done,
    output logic [kpbe_pkg::OUT_W-1:0]        extracted,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kpbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kpbe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import kpbe_pkg::*;

    logic [KLEN_W-1:0] klen_reg;
    logic [POS_W-1:0]  hpos_reg;

    // stage of symbol masks derived from the registers
    logic [POS_W-1:0]  hash_sym_reg, hash_sym_next;
    logic [POS_W-1:0]  rest_sym_reg, rest_sym_next;

    // stage of per-bit destinations derived from the symbol masks
    dest_t hash_dest_reg [KMER_W];
    dest_t bp_dest_reg   [KMER_W];
    dest_t lr_dest_reg   [KMER_W];
    dest_t hash_dest_next [KMER_W];
    dest_t bp_dest_next   [KMER_W];
    dest_t lr_dest_next   [KMER_W];

    // item pipeline
    logic              v1_reg, v2_reg;
    logic [CMD_W-1:0]  cmd1_reg;
    logic [KMER_W-1:0] kmer1_reg;
    logic [OUT_W-1:0]  out_reg, out_next;

    logic settle_reg;
    logic accept;

    assign busy      = settle_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = v2_reg;
    assign extracted = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg <= KLEN_RESET;
            hpos_reg <= HPOS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KMER_LENGTH:      klen_reg <= cfg_data[KLEN_W-1:0];
                REG_HASHED_POSITIONS: hpos_reg <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // destinations trail a write by the mask and destination stages; busy holds off items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 1'b1;
        else
            settle_reg <= cfg_valid && cfg_ready;
    end

    // symbol masks: clamp k, split hashed/rest, keep only the lowest hashed positions
    always_comb
    begin
        logic [KLEN_W-1:0] k_eff;
        logic [POS_W-1:0]  below_k;
        logic [POS_W-1:0]  hashed;
        k_eff = klen_reg;
        if (k_eff == '0)
            k_eff = KLEN_W'(1);
        if (k_eff > KLEN_W'(MAX_KMER_LENGTH))
            k_eff = KLEN_W'(MAX_KMER_LENGTH);
        for (int p = 0; p < POS_W; p++)
            below_k[p] = (KLEN_W'(p) < k_eff);
        hashed        = hpos_reg & below_k;
        rest_sym_next = below_k & ~hashed;
        for (int p = 0; p < POS_W; p++)
            hash_sym_next[p] = hashed[p] &&
                ($countones(hashed & ((POS_W'(1) << p) - POS_W'(1)))
                 < MAX_HASHED_POSITIONS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_sym_reg <= '0;
            rest_sym_reg <= '1;
        end
        else
        begin
            hash_sym_reg <= hash_sym_next;
            rest_sym_reg <= rest_sym_next;
        end
    end

    // destination bit of each selected input bit, from prefix counts of the masks
    always_comb
    begin
        dest_t hc;
        dest_t rc;
        dest_t rtot;
        rtot = DEST_W'($countones(rest_sym_reg));
        for (int p = 0; p < POS_W; p++)
        begin
            hc = DEST_W'($countones(hash_sym_reg & ((POS_W'(1) << p) - POS_W'(1))));
            rc = DEST_W'($countones(rest_sym_reg & ((POS_W'(1) << p) - POS_W'(1))));
            hash_dest_next[2*p]   = DEST_W'({hc, 1'b0});
            hash_dest_next[2*p+1] = DEST_W'({hc, 1'b1});
            bp_dest_next[2*p]     = DEST_W'({rc, 1'b0});
            bp_dest_next[2*p+1]   = DEST_W'({rc, 1'b1});
            lr_dest_next[p]       = rc;
            lr_dest_next[p+POS_W] = rtot + rc;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_dest_reg <= hash_dest_next;
        bp_dest_reg   <= bp_dest_next;
        lr_dest_reg   <= lr_dest_next;
    end

    // keep only the selected bits (unused command selects nothing), then scatter each
    // surviving bit to its destination; destinations >= 32 drop out
    always_comb
    begin
        logic [KMER_W-1:0] hmask;
        logic [KMER_W-1:0] bpmask;
        logic [KMER_W-1:0] lrmask;
        logic [KMER_W-1:0] bits;
        dest_t d;
        for (int p = 0; p < POS_W; p++)
        begin
            hmask[2*p]    = hash_sym_reg[p];
            hmask[2*p+1]  = hash_sym_reg[p];
            bpmask[2*p]   = rest_sym_reg[p];
            bpmask[2*p+1] = rest_sym_reg[p];
        end
        lrmask = {rest_sym_reg, rest_sym_reg};
        case (cmd1_reg)
            CMD_HASH_BP: bits = kmer1_reg & hmask;
            CMD_DROP_LR: bits = kmer1_reg & lrmask;
            CMD_DROP_BP: bits = kmer1_reg & bpmask;
            default:     bits = '0;
        endcase
        out_next = '0;
        for (int b = 0; b < KMER_W; b++)
        begin
            case (cmd1_reg)
                CMD_HASH_BP: d = hash_dest_reg[b];
                CMD_DROP_LR: d = lr_dest_reg[b];
                default:     d = bp_dest_reg[b];
            endcase
            for (int j = 0; j < OUT_W; j++)
                if (d == DEST_W'(j))
                    out_next[j] = out_next[j] | bits[b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd1_reg  <= command;
            kmer1_reg <= encoded_kmer;
        end
        out_reg <= out_next;
    end

endmodule

@@ test/kmer_position_bit_extract_tb.sv @@
// Self-checking testbench for kmer_position_bit_extract: directed table, then randomized
// configuration phases, bursty or steady; checked against table or in-bench predictor.
// Depends on kpbe_pkg and the kmer_position_bit_extract RTL.
module kmer_position_bit_extract_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kpbe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam logic [63:0]      SYMBOL_PAIR  = 64'h0000_0000_0000_0003;
    localparam logic [63:0]      PLANE_PAIR   = 64'h0000_0001_0000_0001;
    localparam logic [63:0]      ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int               RANDOM_ITEMS = 1830;
    localparam int               IDLE_LIMIT   = 500;
    localparam int               DRAIN_CYCLES = 8;
    localparam int               NUM_DIRECTED = 23;

    typedef struct packed {
        logic [KLEN_W-1:0] klen;
        logic [POS_W-1:0]  hpos;
        logic [CMD_W-1:0]  cmd;
        logic [KMER_W-1:0] kmer;
        logic              known;
        logic [OUT_W-1:0]  value;
    } directed_row_t;

    // known = 1: value is the expected result, else the predictor decides
    localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
        '{6'd32, 32'h0000_0000, CMD_HASH_BP, ALL_ONES,              1'b1, 32'h0000_0000},
        '{6'd32, 32'h0000_0000, CMD_HASH_BP, 64'h0123_4567_89AB_CDEF, 1'b1, 32'h0000_0000},
        '{6'd32, 32'h0000_0000, CMD_DROP_LR, 64'h0,                  1'b1, 32'h0000_0000},
        '{6'd32, 32'h0000_0000, CMD_DROP_LR, ALL_ONES,              1'b1, 32'hFFFF_FFFF},
        '{6'd32, 32'h0000_0000, CMD_DROP_LR, 64'h0123_4567_89AB_CDEF, 1'b1, 32'h89AB_CDEF},
        '{6'd32, 32'h0000_0000, CMD_DROP_BP, ALL_ONES,              1'b1, 32'hFFFF_FFFF},
        '{6'd32, 32'h0000_0000, CMD_DROP_BP, 64'hFEDC_BA98_7654_3210, 1'b1, 32'h7654_3210},
        '{6'd32, 32'h0000_0000, CMD_UNUSED,  ALL_ONES,              1'b1, 32'h0000_0000},
        '{6'd32, 32'hFFFF_FFFF, CMD_HASH_BP, 64'h0123_4567_89AB_CDEF, 1'b1, 32'h89AB_CDEF},
        '{6'd32, 32'hFFFF_FFFF, CMD_DROP_BP, ALL_ONES,              1'b1, 32'h0000_0000},
        '{6'd32, 32'hFFFF_FFFF, CMD_DROP_LR, ALL_ONES,              1'b1, 32'h0000_0000},
        '{6'd0,  32'h0000_0000, CMD_DROP_BP, ALL_ONES,              1'b0, 32'h0},
        '{6'd0,  32'h0000_0000, CMD_DROP_LR, ALL_ONES,              1'b0, 32'h0},
        '{6'd0,  32'h0000_0001, CMD_HASH_BP, ALL_ONES,              1'b0, 32'h0},
        '{6'd63, 32'hAAAA_5555, CMD_HASH_BP, 64'h9E37_79B9_7F4A_7C15, 1'b0, 32'h0},
        '{6'd63, 32'hAAAA_5555, CMD_DROP_LR, 64'h9E37_79B9_7F4A_7C15, 1'b0, 32'h0},
        '{6'd63, 32'hAAAA_5555, CMD_DROP_BP, 64'h9E37_79B9_7F4A_7C15, 1'b0, 32'h0},
        '{6'd5,  32'hFFFF_FFF0, CMD_HASH_BP, 64'hC3A5_5A3C_F00F_0FF0, 1'b0, 32'h0},
        '{6'd5,  32'hFFFF_FFF0, CMD_DROP_LR, 64'hC3A5_5A3C_F00F_0FF0, 1'b0, 32'h0},
        '{6'd17, 32'h0001_FFFF, CMD_HASH_BP, ALL_ONES,              1'b0, 32'h0},
        '{6'd17, 32'h0001_FFFF, CMD_DROP_BP, 64'h5555_AAAA_3333_CCCC, 1'b0, 32'h0},
        '{6'd1,  32'h0000_0001, CMD_HASH_BP, 64'h0000_0000_0000_0002, 1'b0, 32'h0},
        '{6'd1,  32'h0000_0001, CMD_DROP_LR, ALL_ONES,              1'b0, 32'h0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      command = '0;
    logic [KMER_W-1:0]     encoded_kmer = '0;
    logic                  done;
    logic [OUT_W-1:0]      extracted;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // bench copy of the registers
    logic [KLEN_W-1:0]     klen_model = KLEN_RESET;
    logic [POS_W-1:0]      hpos_model = HPOS_RESET;

    logic [OUT_W-1:0]      expected_extract_q [$];
    int                    fail_count = 0;
    int                    stall_cycles = 0;

    kmer_position_bit_extract DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .encoded_kmer (encoded_kmer),
        .done         (done),
        .extracted    (extracted),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [OUT_W-1:0] predict_extract(input logic [CMD_W-1:0] cmd,
                                                         input logic [KMER_W-1:0] kmer);
        int          k;
        int          p;
        int          b;
        int          taken;
        int          outpos;
        logic [63:0] below_k;
        logic [63:0] hashed;
        logic [63:0] rest;
        logic [63:0] sel;
        logic [63:0] packed_bits;
        k = int'(klen_model);
        if (k < 1)
            k = 1;
        if (k > MAX_KMER_LENGTH)
            k = MAX_KMER_LENGTH;
        below_k = (64'd1 << k) - 64'd1;
        hashed  = {32'b0, hpos_model} & below_k;
        rest    = below_k & ~hashed;
        sel     = '0;
        taken   = 0;
        for (p = 0; p < k; p++)
        begin
            if (hashed[p])
            begin
                // only the lowest hashed positions enter the hash
                if (cmd == CMD_HASH_BP && taken < MAX_HASHED_POSITIONS)
                    sel |= SYMBOL_PAIR << (2 * p);
                taken++;
            end
            if (rest[p])
            begin
                if (cmd == CMD_DROP_BP)
                    sel |= SYMBOL_PAIR << (2 * p);
                else if (cmd == CMD_DROP_LR)
                    sel |= PLANE_PAIR << p;
            end
        end
        packed_bits = '0;
        outpos = 0;
        for (b = 0; b < 64; b++)
        begin
            if (sel[b])
            begin
                packed_bits[outpos] = kmer[b];
                outpos++;
            end
        end
        return packed_bits[OUT_W-1:0];
    endfunction

    task automatic send_kmer(input logic [CMD_W-1:0] cmd, input logic [KMER_W-1:0] kmer,
                             input logic known, input logic [OUT_W-1:0] known_value);
        logic [OUT_W-1:0] want;
        start        <= 1'b1;
        command      <= cmd;
        encoded_kmer <= kmer;
        do
            @(posedge clk);
        while (busy);
        want = known ? known_value : predict_extract(cmd, kmer);
        expected_extract_q = {expected_extract_q, want};
    endtask

    // leaves cfg_valid high so two writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KMER_LENGTH:      klen_model = data[KLEN_W-1:0];
            REG_HASHED_POSITIONS: hpos_model = data[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [KLEN_W-1:0] klen, input logic [POS_W-1:0] hpos);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        while (expected_extract_q.size() != 0)
            @(posedge clk);
        // upper data bits of the length register are don't-care
        write_reg(REG_KMER_LENGTH, {junk[CFG_DATA_W-1:KLEN_W], klen});
        write_reg(REG_HASHED_POSITIONS, hpos);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        logic [OUT_W-1:0] want;
        if (rst_n && done)
        begin
            if (expected_extract_q.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: unexpected result extracted=%h", $realtime, extracted);
                fail_count++;
            end
            else
            begin
                want = expected_extract_q.pop_front();
                if (extracted !== want)
                begin
                    if (fail_count < 10)
                        $display("%0t: extracted mismatch: expected %h, got %h",
                                 $realtime, want, extracted);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int                remaining;
        int                phase_n;
        int                sent;
        int                burst;
        int                i;
        int                r;
        bit                steady;
        logic [KLEN_W-1:0] klen_pick;
        logic [POS_W-1:0]  hpos_pick;
        logic [CMD_W-1:0]  cmd_pick;
        logic [KMER_W-1:0] kmer_pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].klen != klen_model || DIRECTED[i].hpos != hpos_model)
            begin
                start <= 1'b0;
                set_config(DIRECTED[i].klen, DIRECTED[i].hpos);
            end
            send_kmer(DIRECTED[i].cmd, DIRECTED[i].kmer, DIRECTED[i].known, DIRECTED[i].value);
        end
        start <= 1'b0;

        remaining = RANDOM_ITEMS;
        while (remaining > 0)
        begin
            case ($urandom_range(0, 9))
                0:       klen_pick = 6'd0;
                1:       klen_pick = 6'd1;
                2:       klen_pick = 6'd32;
                3:       klen_pick = 6'($urandom_range(33, 63));
                default: klen_pick = 6'($urandom_range(2, 31));
            endcase
            case ($urandom_range(0, 7))
                0: hpos_pick = '0;
                1: hpos_pick = '1;
                3:
                begin
                    // sparse set, at most the hash capacity
                    hpos_pick = '0;
                    repeat ($urandom_range(1, MAX_HASHED_POSITIONS))
                        hpos_pick[$urandom_range(0, POS_W - 1)] = 1'b1;
                end
                4: hpos_pick = $urandom & $urandom;
                5: hpos_pick = $urandom | $urandom;
                default: hpos_pick = $urandom;
            endcase
            set_config(klen_pick, hpos_pick);

            phase_n = $urandom_range(40, 200);
            if (phase_n > remaining)
                phase_n = remaining;
            steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < phase_n)
            begin
                burst = steady ? phase_n : $urandom_range(1, 32);
                for (i = 0; i < burst && sent < phase_n; i++)
                begin
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        cmd_pick = CMD_UNUSED;
                    else if (r < 6)
                        cmd_pick = CMD_HASH_BP;
                    else if (r < 11)
                        cmd_pick = CMD_DROP_LR;
                    else
                        cmd_pick = CMD_DROP_BP;
                    case ($urandom_range(0, 15))
                        0:       kmer_pick = '0;
                        1:       kmer_pick = ALL_ONES;
                        default: kmer_pick = {$urandom, $urandom};
                    endcase
                    send_kmer(cmd_pick, kmer_pick, 1'b0, '0);
                    sent++;
                end
                start <= 1'b0;
                if (!steady)
                    repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            remaining -= phase_n;
        end

        while (expected_extract_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_extract_q.size();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/kpbe_pkg.sv
hdl/kmer_position_bit_extract.sv
test/kmer_position_bit_extract_tb.sv
